// ===== rtl/core/mia_pkg.sv =====
`default_nettype none
package mia_pkg;
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ROW_BITS      = 2;
    localparam logic [ROW_BITS-1:0] LAST_ROW_IDX = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/core/mia_if.sv =====
`default_nettype none
interface mia_row_if #(parameter int W = 32);
    logic             valid;
    logic             ready;
    logic [1:0]       row_index;
    logic signed [W-1:0] col0_value;
    logic signed [W-1:0] col1_value;
    logic signed [W-1:0] col2_value;
    logic signed [W-1:0] col3_value;
    modport source (output valid, row_index, col0_value, col1_value, col2_value, col3_value,
                    input ready);
    modport sink   (input valid, row_index, col0_value, col1_value, col2_value, col3_value,
                    output ready);
endinterface

interface mia_res_if #(parameter int W = 32);
    logic             valid;
    logic             ready;
    logic [1:0]       out_row;
    logic signed [W-1:0] inv_col0;
    logic signed [W-1:0] inv_col1;
    logic signed [W-1:0] inv_col2;
    logic signed [W-1:0] inv_col3;
    logic             singular_flag;
    logic             saturated_flag;
    logic             last_row;
    modport source (output valid, out_row, inv_col0, inv_col1, inv_col2, inv_col3,
                    singular_flag, saturated_flag, last_row, input ready);
    modport sink   (input valid, out_row, inv_col0, inv_col1, inv_col2, inv_col3,
                    singular_flag, saturated_flag, last_row, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mia_front.sv =====
`default_nettype none
// Front: stores rows; on row 3 pushes a snapshot of the full matrix to the queue.
module mia_front
    import mia_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    mia_row_if.sink                       in_ch,
    output logic                          o_push,
    output logic [16*WORD_BITS-1:0]       o_mat,
    input  wire logic                     i_full
);
    logic [WORD_BITS-1:0] r_store [16];
    logic                 acc;
    logic [1:0]           ri;

    assign ri          = in_ch.row_index;
    assign in_ch.ready = !i_full;
    assign acc         = in_ch.valid && in_ch.ready;
    assign o_push      = acc && (ri == LAST_ROW_IDX);

    always_comb begin
        for (int k = 0; k < 12; k++) begin
            o_mat[k*WORD_BITS +: WORD_BITS] = r_store[k];
        end
        o_mat[12*WORD_BITS +: WORD_BITS] = in_ch.col0_value;
        o_mat[13*WORD_BITS +: WORD_BITS] = in_ch.col1_value;
        o_mat[14*WORD_BITS +: WORD_BITS] = in_ch.col2_value;
        o_mat[15*WORD_BITS +: WORD_BITS] = in_ch.col3_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_store[k] <= '0;
        end else if (acc) begin
            r_store[{ri, 2'd0}] <= in_ch.col0_value;
            r_store[{ri, 2'd1}] <= in_ch.col1_value;
            r_store[{ri, 2'd2}] <= in_ch.col2_value;
            r_store[{ri, 2'd3}] <= in_ch.col3_value;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/mia_queue.sv =====
`default_nettype none
// Two-entry queue of matrix snapshots.
module mia_queue #(
    parameter int DW = 512
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output logic [DW-1:0]      o_data
);
    logic [DW-1:0] r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
endmodule
`default_nettype wire

// ===== rtl/core/mia_back.sv =====
`default_nettype none
// Back: one shared multiplier builds the cofactors and determinant term by term,
// then a bit-serial divider produces each quotient.
module mia_back
    import mia_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [16*WORD_BITS-1:0] i_mat,
    output logic                       o_pop,
    mia_res_if.source                  out_ch
);
    localparam int PW  = 2*WORD_BITS;          // product of two words
    localparam int CW  = 3*WORD_BITS + 3;      // cofactor width
    localparam int DTW = 4*WORD_BITS + 5;      // determinant width
    localparam int NW  = CW + 2*FRAC_BITS;     // shifted numerator width
    localparam int NB  = $clog2(NW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_M1, S_M2, S_M3, S_ACC, S_DET1, S_DET2, S_DIV_INIT, S_DIV,
        S_DIV_DONE, S_EMIT
    } t_state;

    t_state r_state;
    logic [WORD_BITS-1:0]    r_a [16];
    logic signed [CW-1:0]    r_cof [16];
    logic signed [DTW-1:0]   r_det;
    logic [3:0]              r_ci;      // cofactor index i*4+j
    logic [1:0]              r_ck;      // word-sized chunk of a cofactor
    logic [2:0]              r_term;
    logic signed [PW-1:0]    r_p1;
    logic signed [CW-1:0]    r_p2;
    logic signed [CW-1:0]    r_acc;
    logic [1:0]              r_orow, r_ocol;
    logic [DTW-1:0]          r_dmag;
    logic                    r_dneg;
    logic [NW-1:0]           r_num;
    logic [DTW:0]            r_rem;
    logic [NW-1:0]           r_q;
    logic [NB-1:0]           r_bit;
    logic                    r_qneg;
    logic [WORD_BITS-1:0]    r_res [4];
    logic                    r_sat;

    // Operands of the current term of the current minor.
    logic [1:0] rw0, rw1, rw2, cl0, cl1, cl2, ii, jj;
    logic [1:0] ra, rb, rc, ca, cb, cc;
    logic       tsub;
    logic signed [WORD_BITS-1:0] opx, opy, opz;
    always_comb begin
        ii = r_ci[3:2]; jj = r_ci[1:0];
        rw0 = (ii == 2'd0) ? 2'd1 : 2'd0;
        rw1 = (ii <= 2'd1) ? 2'd2 : 2'd1;
        rw2 = (ii == 2'd3) ? 2'd2 : 2'd3;
        cl0 = (jj == 2'd0) ? 2'd1 : 2'd0;
        cl1 = (jj <= 2'd1) ? 2'd2 : 2'd1;
        cl2 = (jj == 2'd3) ? 2'd2 : 2'd3;
        tsub = 1'b0;
        ra = rw0; ca = cl0; rb = rw1; cb = cl1; rc = rw2; cc = cl2;
        unique case (r_term)
            3'd0: begin ra = rw0; ca = cl0; rb = rw1; cb = cl1; rc = rw2; cc = cl2; end
            3'd1: begin ra = rw1; ca = cl0; rb = rw2; cb = cl1; rc = rw0; cc = cl2; end
            3'd2: begin ra = rw0; ca = cl1; rb = rw1; cb = cl2; rc = rw2; cc = cl0; end
            3'd3: begin ra = rw0; ca = cl2; rb = rw1; cb = cl1; rc = rw2; cc = cl0;
                        tsub = 1'b1; end
            3'd4: begin ra = rw1; ca = cl0; rb = rw0; cb = cl1; rc = rw2; cc = cl2;
                        tsub = 1'b1; end
            3'd5: begin ra = rw0; ca = cl0; rb = rw2; cb = cl1; rc = rw1; cc = cl2;
                        tsub = 1'b1; end
            default: ;
        endcase
        opx = r_a[{ra, ca}];
        opy = r_a[{rb, cb}];
        opz = r_a[{rc, cc}];
    end

    // The one multiplier, a word plus a sign bit by a word. Wider products are
    // built from word-sized chunks, the top chunk signed and the others not.
    logic signed [4*WORD_BITS-1:0] cof_ext;
    logic [WORD_BITS-1:0]          det_chunk;
    logic signed [WORD_BITS:0]     m_a;
    logic signed [WORD_BITS-1:0]   m_b;
    logic signed [2*WORD_BITS:0]   m_p;
    always_comb begin
        cof_ext   = (4*WORD_BITS)'(r_cof[r_ci]);
        det_chunk = cof_ext[r_ck*WORD_BITS +: WORD_BITS];
        m_a = {opx[WORD_BITS-1], opx};
        m_b = opy;
        case (r_state)
            S_M2: begin
                m_a = {1'b0, r_p1[WORD_BITS-1:0]};
                m_b = opz;
            end
            S_M3: begin
                m_a = {r_p1[PW-1], r_p1[PW-1:WORD_BITS]};
                m_b = opz;
            end
            S_DET1: begin
                m_a = (r_ck == 2'd3) ? {det_chunk[WORD_BITS-1], det_chunk}
                                     : {1'b0, det_chunk};
                m_b = $signed(r_a[{2'd0, r_ci[1:0]}]);
            end
            default: ;
        endcase
        m_p = (2*WORD_BITS+1)'(m_a) * (2*WORD_BITS+1)'(m_b);
    end

    logic signed [CW-1:0] cof_sel, cof_mag;
    logic                 cof_neg;
    logic [DTW:0]         rem_sh;
    logic [DTW:0]         rem_sub;
    logic [WORD_BITS-1:0] pos_lim, neg_lim;
    logic                 qhi;
    logic [WORD_BITS-1:0] qlo;
    logic [WORD_BITS-1:0] qval;
    logic                 qsat;
    always_comb begin
        cof_sel = r_cof[{r_ocol, r_orow}];
        cof_neg = cof_sel[CW-1];
        cof_mag = cof_neg ? -cof_sel : cof_sel;
        rem_sh  = {r_rem[DTW-1:0], r_num[NW-1]};
        rem_sub = rem_sh - {1'b0, r_dmag};
        pos_lim = {1'b0, {(WORD_BITS-1){1'b1}}};
        neg_lim = {1'b1, {(WORD_BITS-1){1'b0}}};
        qhi     = |r_q[NW-1:WORD_BITS];
        qlo     = r_q[WORD_BITS-1:0];
        qsat    = 1'b0;
        qval    = qlo;
        if (!r_qneg && (qhi || qlo > pos_lim)) begin qval = pos_lim; qsat = 1'b1; end
        if (r_qneg && (qhi || qlo > neg_lim))  begin qval = neg_lim; qsat = 1'b1; end
        if (r_qneg) qval = -qval;
    end

    logic singular;
    assign singular = (r_det == '0);
    assign o_pop    = (r_state == S_LOAD);

    assign out_ch.valid          = (r_state == S_EMIT);
    assign out_ch.out_row        = r_orow;
    assign out_ch.inv_col0       = r_res[0];
    assign out_ch.inv_col1       = r_res[1];
    assign out_ch.inv_col2       = r_res[2];
    assign out_ch.inv_col3       = r_res[3];
    assign out_ch.singular_flag  = singular;
    assign out_ch.saturated_flag = r_sat;
    assign out_ch.last_row       = (r_orow == LAST_ROW_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ci <= '0; r_ck <= '0; r_term <= '0; r_orow <= '0; r_ocol <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_LOAD;
                S_LOAD: begin
                    for (int k = 0; k < 16; k++) r_a[k] <= i_mat[k*WORD_BITS +: WORD_BITS];
                    r_ci <= '0; r_term <= '0; r_acc <= '0;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_p1 <= PW'(m_p);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_p2 <= CW'(m_p);
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_p2 <= r_p2 + (CW'(m_p) <<< WORD_BITS);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_term == 3'd5) begin
                        r_cof[r_ci] <= (ii[0] ^ jj[0]) ? -(r_acc - r_p2) : (r_acc - r_p2);
                        r_acc <= '0; r_term <= '0;
                        if (r_ci == 4'd15) begin
                            r_ci <= '0; r_ck <= '0; r_det <= '0; r_state <= S_DET1;
                        end else begin
                            r_ci <= r_ci + 4'd1; r_state <= S_M1;
                        end
                    end else begin
                        r_acc <= tsub ? r_acc - r_p2 : r_acc + r_p2;
                        r_term <= r_term + 3'd1;
                        r_state <= S_M1;
                    end
                end
                S_DET1: begin
                    r_det <= r_det + (DTW'(m_p) <<< (WORD_BITS * r_ck));
                    if (r_ck == 2'd3) begin
                        r_ck <= '0;
                        if (r_ci == 4'd3) r_state <= S_DET2;
                        else r_ci <= r_ci + 4'd1;
                    end else begin
                        r_ck <= r_ck + 2'd1;
                    end
                end
                S_DET2: begin
                    r_dneg <= r_det[DTW-1];
                    r_dmag <= r_det[DTW-1] ? DTW'(-r_det) : DTW'(r_det);
                    r_orow <= '0; r_ocol <= '0; r_sat <= 1'b0;
                    r_state <= S_DIV_INIT;
                end
                S_DIV_INIT: begin
                    r_num  <= NW'(cof_mag) << (2*FRAC_BITS);
                    r_qneg <= cof_neg ^ r_dneg;
                    r_rem  <= '0; r_q <= '0;
                    r_bit  <= NB'(NW);
                    r_state <= singular ? S_DIV_DONE : S_DIV;
                end
                S_DIV: begin
                    r_num <= r_num << 1;
                    if (!rem_sub[DTW]) begin
                        r_rem <= rem_sub; r_q <= {r_q[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;  r_q <= {r_q[NW-2:0], 1'b0};
                    end
                    r_bit <= r_bit - NB'(1);
                    if (r_bit == NB'(1)) r_state <= S_DIV_DONE;
                end
                S_DIV_DONE: begin
                    r_res[r_ocol] <= singular ? '0 : ((r_q == '0) ? '0 : qval);
                    if (!singular && qsat) r_sat <= 1'b1;
                    r_ocol <= r_ocol + 2'd1;
                    r_state <= (r_ocol == 2'd3) ? S_EMIT : S_DIV_INIT;
                end
                S_EMIT: if (out_ch.ready) begin
                    r_sat <= 1'b0;
                    r_orow <= r_orow + 2'd1;
                    r_state <= (r_orow == 2'd3) ? S_IDLE : S_DIV_INIT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pop_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_valid) else $error("pop without data");
    a_sing_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.singular_flag) |-> !out_ch.saturated_flag)
        else $error("saturated on singular");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
endmodule
`default_nettype wire

// ===== rtl/core/matrix4_inverse_adjugate.sv =====
`default_nettype none
// 4x4 matrix inverse by cofactors and adjugate, signed fixed point.
// The input channel carries one matrix row per beat; rows 0..2 are only
// stored, and a beat carrying row 3 hands a snapshot of the whole matrix to
// a two-entry queue, so the front keeps taking rows while the back works.
// The back computes sixteen 3x3 cofactors with one shared multiplier of about
// word by word size (six terms each, each term built in the states M1, M2, M3
// and ACC), expands the determinant along row 0, and divides each adjugate
// entry with a restoring divider at one quotient bit per cycle, skipped for a
// singular matrix. The back takes a new matrix only once the last result beat
// of the current one has been accepted. Result beats leave in row order; the
// last carries last_row.
// A singular matrix gives all-zero entries with singular_flag set.
// Reset clears the stored matrix to zero, empties the queue and idles the
// back. When the receiver stalls, the current result beat holds; the front
// stalls only once two matrices are waiting in the queue.
module matrix4_inverse_adjugate
    import mia_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mia_row_if.sink   in_ch,
    mia_res_if.source out_ch
);
    localparam int DW = 16*WORD_BITS;

    // Snapshot traffic from the front through the queue to the back.
    logic          push, full, qvalid, pop;
    logic [DW-1:0] mat_in, mat_out;

    mia_front #(.WORD_BITS(WORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_push(push), .o_mat(mat_in), .i_full(full)
    );

    mia_queue #(.DW(DW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(mat_in),
        .o_full(full), .o_valid(qvalid), .i_pop(pop), .o_data(mat_out)
    );

    mia_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(qvalid), .i_mat(mat_out),
        .o_pop(pop), .out_ch(out_ch)
    );
endmodule
`default_nettype wire
